[sv/esfp_pkg.sv]
package esfp_pkg;

  // Field geometry
  localparam int FIELD_CHARS = 16;
  localparam int MAX_FIELDS  = 15;

  localparam int CHAR_CNT_W  = $clog2(FIELD_CHARS);
  localparam int FIELD_NUM_W = $clog2(MAX_FIELDS + 1);

  // Fields that carry numbers
  localparam int SEV_FIELD  = 2;
  localparam int CODE_FIELD = 3;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_X_LOWER = 8'h78;
  localparam logic [7:0] CH_X_UPPER = 8'h58;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_VTAB    = 8'h0B;
  localparam logic [7:0] CH_FFEED   = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_sentence;
  } esfp_word_t;

  typedef struct packed {
    logic [7:0]  severity;
    logic [15:0] error_code;
    logic        severity_present;
    logic        code_present;
  } esfp_result_t;

endpackage

[sv/esfp_if.sv]
interface esfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_sentence;

  modport source (output valid, output char_in, output end_of_sentence, input ready);
  modport sink   (input valid, input char_in, input end_of_sentence, output ready);
endinterface

interface esfp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  severity;
  logic [15:0] error_code;
  logic        severity_present;
  logic        code_present;

  modport source (output valid, output severity, output error_code,
                  output severity_present, output code_present, input ready);
  modport sink   (input valid, input severity, input error_code,
                  input severity_present, input code_present, output ready);
endinterface

[sv/esfp_char_stage.sv]
module esfp_char_stage
  import esfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  esfp_in_if.sink     in_chan,
  input  logic        advance,
  output logic        word_valid,
  output esfp_word_t  word
);

  logic       valid_r;
  logic       valid_nxt;
  esfp_word_t word_r;
  logic       take;

  assign in_chan.ready = !valid_r || advance;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r.char_in         <= in_chan.char_in;
      word_r.end_of_sentence <= in_chan.end_of_sentence;
    end
  end

  assign word_valid = valid_r;
  assign word       = word_r;

endmodule

[sv/esfp_field_parser.sv]
module esfp_field_parser
  import esfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         advance,
  input  esfp_word_t   word,
  output esfp_result_t result
);

  typedef enum logic [2:0] {
    PH_BLANKS,
    PH_SIGN,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS,
    PH_STOP
  } phase_t;

  logic [FIELD_NUM_W-1:0] field_r, field_nxt;
  logic [CHAR_CNT_W-1:0]  chars_r, chars_nxt;
  phase_t                 phase_r, phase_nxt;
  logic                   neg_r, neg_nxt;
  logic [15:0]            run_r, run_nxt;
  logic [7:0]             sev_r, sev_nxt;
  logic                   sev_pres_r, sev_pres_nxt;
  logic [15:0]            code_r, code_nxt;
  logic                   code_pres_r, code_pres_nxt;

  logic [7:0]  c;
  logic        is_delim;
  logic        is_blank;
  logic        is_sev;
  logic        is_code;
  logic        hex;
  logic [4:0]  dig;
  logic        dig_ok;
  logic [15:0] acc;
  logic [15:0] signed_val;
  logic        first_sig;

  // Digit value in the given base, 16 when not a digit
  function automatic logic [4:0] digit_of(input logic [7:0] ch, input logic hex_base);
    logic [4:0] d;
    d = 5'd16;
    if (ch inside {[8'h30:8'h39]}) begin
      d = 5'(ch - 8'h30);
    end else if (hex_base && (ch inside {[8'h61:8'h66]})) begin
      d = 5'(ch - 8'h61 + 8'd10);
    end else if (hex_base && (ch inside {[8'h41:8'h46]})) begin
      d = 5'(ch - 8'h41 + 8'd10);
    end
    return d;
  endfunction

  assign c        = word.char_in;
  assign is_delim = (c == CH_COMMA) || (c == CH_NEWLINE) || (c == CH_STAR);
  assign is_blank = c inside {CH_SPACE, CH_TAB, CH_VTAB, CH_FFEED, CH_CR};
  assign is_sev   = (field_r == FIELD_NUM_W'(SEV_FIELD));
  assign is_code  = (field_r == FIELD_NUM_W'(CODE_FIELD));
  assign hex      = is_code;
  assign dig      = digit_of(c, hex);
  assign dig_ok   = !dig[4];

  // Shift-add: x16 or x10 plus the digit, wrapped to 16 bits
  assign acc = hex ? {run_r[11:0], dig[3:0]}
                   : ({run_r[12:0], 3'b000} + {run_r[14:0], 1'b0} + {12'd0, dig[3:0]});
  assign signed_val = neg_r ? (16'd0 - run_r) : run_r;

  always_comb begin
    field_nxt     = field_r;
    chars_nxt     = chars_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    run_nxt       = run_r;
    sev_nxt       = sev_r;
    sev_pres_nxt  = sev_pres_r;
    code_nxt      = code_r;
    code_pres_nxt = code_pres_r;
    first_sig     = 1'b0;

    if (is_delim) begin
      if (is_sev) begin
        sev_nxt      = signed_val[7:0];
        sev_pres_nxt = 1'b1;
      end else if (is_code) begin
        code_nxt      = signed_val;
        code_pres_nxt = 1'b1;
      end
      if (field_r < FIELD_NUM_W'(MAX_FIELDS)) begin
        field_nxt = field_r + FIELD_NUM_W'(1);
      end
      chars_nxt = '0;
      phase_nxt = PH_BLANKS;
      neg_nxt   = 1'b0;
      run_nxt   = '0;
    end else if (chars_r < CHAR_CNT_W'(FIELD_CHARS - 1)) begin
      chars_nxt = chars_r + CHAR_CNT_W'(1);
      if (is_sev || is_code) begin
        case (phase_r)
          PH_BLANKS: begin
            if (is_blank) begin
              phase_nxt = PH_BLANKS;
            end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
              neg_nxt   = (c == CH_MINUS);
              phase_nxt = PH_SIGN;
            end else begin
              first_sig = 1'b1;
            end
          end
          PH_SIGN: begin
            first_sig = 1'b1;
          end
          PH_ZERO: begin
            if ((c == CH_X_LOWER) || (c == CH_X_UPPER)) begin
              phase_nxt = PH_PREFIX;
            end else if (dig_ok) begin
              run_nxt   = acc;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          PH_PREFIX, PH_DIGITS: begin
            if (dig_ok) begin
              run_nxt   = acc;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase

        if (first_sig) begin
          if (hex && (c == CH_ZERO)) begin
            phase_nxt = PH_ZERO;
          end else if (dig_ok) begin
            run_nxt   = acc;
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_STOP;
          end
        end
      end
    end
  end

  // Result reflects this word's effect before the sentence state clears
  assign result.severity         = sev_nxt;
  assign result.error_code       = code_nxt;
  assign result.severity_present = sev_pres_nxt;
  assign result.code_present     = code_pres_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && word.end_of_sentence)) begin
      field_r     <= '0;
      chars_r     <= '0;
      phase_r     <= PH_BLANKS;
      neg_r       <= 1'b0;
      run_r       <= '0;
      sev_r       <= '0;
      sev_pres_r  <= 1'b0;
      code_r      <= '0;
      code_pres_r <= 1'b0;
    end else if (advance) begin
      field_r     <= field_nxt;
      chars_r     <= chars_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      run_r       <= run_nxt;
      sev_r       <= sev_nxt;
      sev_pres_r  <= sev_pres_nxt;
      code_r      <= code_nxt;
      code_pres_r <= code_pres_nxt;
    end
  end

endmodule

[sv/esfp_out_reg.sv]
module esfp_out_reg
  import esfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  esfp_result_t result,
  output logic         free,
  esfp_out_if.source   out_chan
);

  logic         valid_r;
  logic         valid_nxt;
  esfp_result_t res_r;

  assign free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_chan.valid            = valid_r;
  assign out_chan.severity         = res_r.severity;
  assign out_chan.error_code       = res_r.error_code;
  assign out_chan.severity_present = res_r.severity_present;
  assign out_chan.code_present     = res_r.code_present;

endmodule

[sv/error_sentence_field_parser_unit.sv]
// Channel   Dir  Handshake          Word
// in_chan   in   valid/ready        char_in[7:0], end_of_sentence
// out_chan  out  valid/ready        severity[7:0], error_code[15:0],
//                                   severity_present, code_present
//
// One character a cycle while no last character waits for the result register:
// a word is held in the input register, then the field parser updates its state
// and, on the last character, loads the result register, which presents it.
// Reset (rst_n low, synchronous) empties both registers and clears the parser.
// A stalled result holds the last character of the next sentence in the input
// register and stalls the input; characters ahead of it keep flowing.
module error_sentence_field_parser_unit
  import esfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  esfp_in_if.sink     in_chan,
  esfp_out_if.source  out_chan
);

  logic         word_valid;
  esfp_word_t   word;
  logic         advance;
  logic         out_free;
  esfp_result_t result;

  // Hold a last character until the result register has room
  assign advance = word_valid && (!word.end_of_sentence || out_free);

  esfp_char_stage u_char_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  esfp_field_parser u_field_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .word    (word),
    .result  (result)
  );

  esfp_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance && word.end_of_sentence),
    .result   (result),
    .free     (out_free),
    .out_chan (out_chan)
  );

endmodule

[sv/esfp_checker.sv]
module esfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  severity,
  input logic [15:0] error_code,
  input logic        severity_present,
  input logic        code_present
);

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_absent_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((severity_present || (severity == 8'd0)) &&
                   (code_present || (error_code == 16'd0))))
    else $error("absent field carries a nonzero value");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(severity) &&
      $stable(error_code) && $stable(severity_present) && $stable(code_present)))
    else $error("stalled result changed");

endmodule

bind error_sentence_field_parser_unit esfp_checker u_esfp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .severity         (out_chan.severity),
  .error_code       (out_chan.error_code),
  .severity_present (out_chan.severity_present),
  .code_present     (out_chan.code_present)
);

[sim/tb_error_sentence_field_parser_unit.sv]
module tb_error_sentence_field_parser_unit;
  import esfp_pkg::*;

  typedef enum logic [2:0] {
    SKIP_BLANKS,
    AFTER_SIGN,
    LEAD_ZERO,
    AFTER_PREFIX,
    IN_DIGITS,
    HALTED
  } num_phase_e;

  logic clk;
  logic rst_n;

  esfp_in_if  in_chan();
  esfp_out_if out_chan();

  error_sentence_field_parser_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  esfp_word_t   pending_chars[$];
  esfp_result_t awaited_results[$];
  int           mismatch_count = 0;

  // Parser state as the block should hold it
  int          sent_field = 0;
  int          field_len  = 0;
  num_phase_e  conv_phase = SKIP_BLANKS;
  logic        conv_neg   = 1'b0;
  logic [15:0] conv_acc   = '0;
  logic [7:0]  sev_held   = '0;
  logic        sev_seen   = 1'b0;
  logic [15:0] code_held  = '0;
  logic        code_seen  = 1'b0;

  // Sender and receiver pacing
  int          burst_left   = 0;
  int          gap_left     = 0;
  int          stall_cycle  = 0;
  logic [15:0] stall_pattern = 16'hFFFF;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 200000);
    $display("error_sentence_field_parser_unit: mismatch");
    $finish;
  end

  function automatic logic is_blank(logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_VTAB, CH_FFEED, CH_CR};
  endfunction

  function automatic int digit_value(logic [7:0] c, int base);
    int d;
    d = 16;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "f") d = c - "a" + 10;
    else if (c >= "A" && c <= "F") d = c - "A" + 10;
    return (d < base) ? d : 16;
  endfunction

  function automatic void restart_field();
    field_len  = 0;
    conv_phase = SKIP_BLANKS;
    conv_neg   = 1'b0;
    conv_acc   = '0;
  endfunction

  function automatic void accumulate(int d, int base);
    conv_acc   = 16'(32'(conv_acc) * base + d);
    conv_phase = IN_DIGITS;
  endfunction

  // strtol-like conversion, one character at a time
  function automatic void step_number(logic [7:0] c, int base);
    int d;
    d = digit_value(c, base);
    case (conv_phase)
      SKIP_BLANKS, AFTER_SIGN: begin
        if (conv_phase == SKIP_BLANKS && is_blank(c)) begin
        end else if (conv_phase == SKIP_BLANKS && (c == CH_PLUS || c == CH_MINUS)) begin
          conv_neg   = (c == CH_MINUS);
          conv_phase = AFTER_SIGN;
        end else if (base == 16 && c == CH_ZERO) begin
          conv_phase = LEAD_ZERO;
        end else if (d < 16) begin
          accumulate(d, base);
        end else begin
          conv_phase = HALTED;
        end
      end
      LEAD_ZERO: begin
        if (c == CH_X_LOWER || c == CH_X_UPPER) conv_phase = AFTER_PREFIX;
        else if (d < 16) accumulate(d, base);
        else conv_phase = HALTED;
      end
      AFTER_PREFIX, IN_DIGITS: begin
        if (d < 16) accumulate(d, base);
        else conv_phase = HALTED;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void parse_sentence_char(logic [7:0] c, logic last);
    logic [15:0]  v;
    esfp_result_t r;
    if (c == CH_COMMA || c == CH_NEWLINE || c == CH_STAR) begin
      v = conv_neg ? 16'(16'd0 - conv_acc) : conv_acc;
      if (sent_field == SEV_FIELD) begin
        sev_held = v[7:0];
        sev_seen = 1'b1;
      end else if (sent_field == CODE_FIELD) begin
        code_held = v;
        code_seen = 1'b1;
      end
      if (sent_field < MAX_FIELDS) sent_field++;
      restart_field();
    end else if (field_len < FIELD_CHARS - 1) begin
      field_len++;
      if (sent_field == SEV_FIELD) step_number(c, 10);
      else if (sent_field == CODE_FIELD) step_number(c, 16);
    end
    if (last) begin
      r.severity         = sev_seen ? sev_held : '0;
      r.error_code       = code_seen ? code_held : '0;
      r.severity_present = sev_seen;
      r.code_present     = code_seen;
      awaited_results.push_back(r);
      sent_field = 0;
      restart_field();
      sev_held  = '0;
      sev_seen  = 1'b0;
      code_held = '0;
      code_seen = 1'b0;
    end
  endfunction

  function automatic void push_char(logic [7:0] c);
    esfp_word_t w;
    w.char_in         = c;
    w.end_of_sentence = 1'b0;
    pending_chars.push_back(w);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endfunction

  // Flag the last queued word as the end of its sentence
  function automatic void close_sentence();
    esfp_word_t w;
    w = pending_chars.pop_back();
    w.end_of_sentence = 1'b1;
    pending_chars.push_back(w);
  endfunction

  function automatic void push_delim();
    case ($urandom_range(0, 9))
      8: begin
        push_char(CH_STAR);
      end
      9: begin
        push_char(CH_NEWLINE);
      end
      default: begin
        push_char(CH_COMMA);
      end
    endcase
  endfunction

  function automatic void push_filler();
    string alnum;
    alnum = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 .";
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 9) == 0) push_char(8'($urandom_range(33, 126)));
      else push_char(alnum[$urandom_range(0, alnum.len() - 1)]);
    end
  endfunction

  function automatic void push_number(logic hex);
    string digs;
    int    n;
    digs = hex ? "0123456789abcdefABCDEF" : "0123456789";
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 4))
          0: push_char(CH_SPACE);
          1: push_char(CH_TAB);
          2: push_char(CH_VTAB);
          3: push_char(CH_FFEED);
          default: push_char(CH_CR);
        endcase
      end
    end
    case ($urandom_range(0, 9))
      0: begin
        push_char(CH_PLUS);
      end
      1, 2: begin
        push_char(CH_MINUS);
      end
      3: begin
        push_char(CH_MINUS);
        push_char(CH_PLUS);
      end
      default: begin
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      push_char(CH_ZERO);
      push_char($urandom_range(0, 1) ? CH_X_LOWER : CH_X_UPPER);
    end
    case ($urandom_range(0, 9))
      0: n = 0;
      9: n = $urandom_range(10, 18);
      default: n = $urandom_range(1, hex ? 4 : 3);
    endcase
    repeat (n) push_char(digs[$urandom_range(0, digs.len() - 1)]);
    if ($urandom_range(0, 5) == 0) push_char(8'($urandom_range(0, 255)));
  endfunction

  // Mostly well-formed sentences, some cut short, some pure noise
  function automatic void add_random_sentence();
    int start;
    int kind;
    int k;
    start = pending_chars.size();
    kind  = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 30)) push_char(8'($urandom_range(0, 255)));
    end else begin
      push_filler();
      push_delim();
      push_filler();
      push_delim();
      push_number(1'b0);
      push_delim();
      push_number(1'b1);
      k = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : $urandom_range(0, 2);
      repeat (k) begin
        push_delim();
        push_filler();
      end
      push_delim();
      if (kind == 1) begin
        repeat ($urandom_range(0, pending_chars.size() - start - 1))
          void'(pending_chars.pop_back());
      end
    end
    close_sentence();
  endfunction

  function automatic void compare_field(string what, int want, int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  initial begin
    rst_n                   = 1'b0;
    in_chan.valid           = 1'b0;
    in_chan.char_in         = '0;
    in_chan.end_of_sentence = 1'b0;
    out_chan.ready          = 1'b0;

    push_text("ER,1,-12,0x1F3a,z\n");
    close_sentence();
    push_char(CH_COMMA);
    close_sentence();
    push_text(",,255,FFFF*");
    close_sentence();
    push_text(",,");
    push_char(CH_SPACE);
    push_char(CH_TAB);
    push_text("+300,");
    push_char(CH_VTAB);
    push_char(CH_FFEED);
    push_char(CH_CR);
    push_text("-0X10\n");
    close_sentence();
    push_text(",,12a,0xg,");
    close_sentence();
    push_text(",,99999999999999999,123456789abcdef0123,");
    close_sentence();
    push_text(",,7");
    close_sentence();
    push_text(",,");
    push_char(8'h00);
    push_text("5,");
    push_char(8'hFF);
    push_text("1,");
    close_sentence();
    push_text(",,1,2,,,,,,,,,,,,,,,,,3,4,");
    close_sentence();
    push_text(",,0x5,0ab,-");
    close_sentence();
    push_text(",,-1,-,");
    close_sentence();
    push_text(",,+-5,0x,");
    close_sentence();

    while (pending_chars.size() < 1200) add_random_sentence();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_chars.size() != 0 || in_chan.valid || awaited_results.size() != 0);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("error_sentence_field_parser_unit: match");
    end else begin
      $display("error_sentence_field_parser_unit: mismatch");
    end
    $finish;
  end

  // Driver: bursts of words with random gaps
  always @(posedge clk) begin
    esfp_word_t w;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready)
        parse_sentence_char(in_chan.char_in, in_chan.end_of_sentence);
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0 || pending_chars.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_chan.valid <= 1'b0;
        end else begin
          w = pending_chars.pop_front();
          in_chan.valid           <= 1'b1;
          in_chan.char_in         <= w.char_in;
          in_chan.end_of_sentence <= w.end_of_sentence;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
  end

  // Monitor: check each result word, stall on a rotating pattern
  always @(posedge clk) begin
    esfp_result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: expected no result, got severity %0h code %0h", $time,
                   out_chan.severity, out_chan.error_code);
        end else begin
          want = awaited_results.pop_front();
          compare_field("severity", want.severity, out_chan.severity);
          compare_field("error_code", want.error_code, out_chan.error_code);
          compare_field("severity_present", want.severity_present,
                        out_chan.severity_present);
          compare_field("code_present", want.code_present, out_chan.code_present);
        end
      end
      stall_cycle++;
      if (stall_cycle % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = 16'hFFFF;
          1: stall_pattern = 16'($urandom);
          2: stall_pattern = 16'($urandom & $urandom);
          default: stall_pattern = 16'($urandom | $urandom);
        endcase
        if (stall_pattern == '0) stall_pattern = 16'h0001;
      end
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      out_chan.ready <= stall_pattern[0];
    end
  end

endmodule
